### rtl/bss_pkg.sv
// Package for the bounded substring search: codes, limits and cell control type.
package bss_pkg;

  localparam int unsigned PATTERN_MAX_DEF = 64;
  localparam int unsigned MAX_STRING      = 4096;

  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned BYTE_W  = 8;

  localparam logic [LIMIT_W-1:0] TEXT_LIMIT_RST    = 16'd4096;
  localparam logic [LIMIT_W-1:0] PATTERN_LIMIT_RST = 16'd64;

  // Register index, taken from paddr[2]
  localparam logic REG_TEXT_LIMIT    = 1'b0;
  localparam logic REG_PATTERN_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_TEXT    = 2'd2,
    OP_END     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_ZERO     = 3'd2,
    ST_TOOLARGE = 3'd3,
    ST_TOOLONG  = 3'd4
  } status_t;

  // Broadcast control for the row of match cells
  typedef struct packed {
    logic              clear;
    logic              step;
    logic [BYTE_W-1:0] data;
  } cell_ctl_t;

endpackage

### rtl/bss_cell.sv
// One match cell: holds a pattern byte and its partial-match flag.
module bss_cell
  import bss_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic              load,
  input  logic              pm_in,
  output logic              pm_out,
  output logic              hit
);

  logic [BYTE_W-1:0] pat_r;
  logic              pm_r;

  // Match extends from the left neighbor when this byte agrees
  assign hit    = pm_in & (pat_r == ctl.data);
  assign pm_out = pm_r;

  always_ff @(posedge clk) begin
    if (load) begin
      pat_r <= ctl.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_r <= 1'b0;
    end else if (ctl.clear) begin
      pm_r <= 1'b0;
    end else if (ctl.step) begin
      pm_r <= hit;
    end
  end

endmodule

### rtl/bounded_substring_search_top.sv
// Top level of the bounded substring search: control, cell row and ports.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------------
//   in_     | sink      | in_tvalid / in_tready  | tuser: op, tdata: data_byte
//   out_    | source    | out_tvalid / out_tready| tuser: status, tdata: position
//   cfg_    | APB slave | psel+penable, pready=1 | text_limit @0, pattern_limit @4
//
// The row of cells compares a text byte against all pattern bytes at once, so a
// new beat is taken in every cycle unless a waiting result holds in_tready low.
// A result appears in the output register the cycle after the beat that caused it.
// in_tready drops only while a result waits and out_tready is low.
// Reset (rst_n low, synchronous) leaves the block idle until a start beat.
module bounded_substring_search_top
  import bss_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] data_byte
  input  logic [1:0]          in_tuser,   // [1:0] op
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata,  // [11:0] position, [15:12] zero
  output logic [2:0]          out_tuser,  // [2:0] status
  // configuration
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  localparam int unsigned CW = $clog2(PATTERN_MAX + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [LIMIT_W-1:0] tlim_r;
  logic [LIMIT_W-1:0] plim_r;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tlim_r <= TEXT_LIMIT_RST;
      plim_r <= PATTERN_LIMIT_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_TEXT_LIMIT) begin
        tlim_r <= cfg_pwdata[LIMIT_W-1:0];
      end else begin
        plim_r <= cfg_pwdata[LIMIT_W-1:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_PATTERN_LIMIT) ? {16'd0, plim_r}
                                                          : {16'd0, tlim_r};

  // ---------------------------------------------------------------------------
  // Search state
  // ---------------------------------------------------------------------------
  logic               done_r,  done_nxt;   // idle until start
  logic               text_r,  text_nxt;   // text phase began
  logic [CW-1:0]      cnt_r,   cnt_nxt;    // loaded pattern bytes
  logic               ovf_r,   ovf_nxt;    // pattern bytes beyond the row
  logic [LIMIT_W-1:0] tc_r,    tc_nxt;     // text bytes seen
  logic [CW-1:0]      ml_r,    ml_nxt;     // effective match length

  logic               out_valid_r, out_valid_nxt;
  status_t            status_r,    status_nxt;
  logic [POS_W-1:0]   pos_r,       pos_nxt;

  op_t                op;
  logic [BYTE_W-1:0]  b;
  logic               acc;

  assign op        = op_t'(in_tuser);
  assign b         = in_tdata;
  assign in_tready = ~out_valid_r | out_tready;
  assign acc       = in_tvalid & in_tready;

  // Pattern resolution at the first text beat
  logic [LIMIT_W-1:0] cnt16;
  logic [LIMIT_W-1:0] ml_res16;
  logic [CW-1:0]      ml_res;
  logic [CW-1:0]      ml_cur;
  logic               res_empty;
  logic               too_long;

  assign cnt16     = LIMIT_W'(cnt_r);
  assign res_empty = (cnt_r == '0) & ~ovf_r;
  assign too_long  = ovf_r & (plim_r > LIMIT_W'(PATTERN_MAX));
  assign ml_res16  = ovf_r ? plim_r : ((cnt16 < plim_r) ? cnt16 : plim_r);
  assign ml_res    = ml_res16[CW-1:0];
  assign ml_cur    = text_r ? ml_r : ml_res;

  // ---------------------------------------------------------------------------
  // Row of match cells
  // ---------------------------------------------------------------------------
  cell_ctl_t              ctl;
  logic                   row_clear;
  logic                   pat_ld;
  logic                   step;
  logic [PATTERN_MAX-1:0] hit;
  logic [PATTERN_MAX-1:0] pm;
  logic [PATTERN_MAX-1:0] last;
  logic                   found_bit;

  assign ctl = '{clear: row_clear, step: step, data: b};

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic ld;
    logic pm_in;

    assign ld    = pat_ld & (cnt_r == CW'(k));
    // Cell zero always starts a fresh match
    if (k == 0) begin : g_head
      assign pm_in = 1'b1;
    end else begin : g_link
      assign pm_in = pm[k-1];
    end
    // Only the cell at the end of the effective pattern reports a match
    assign last[k] = (ml_cur == CW'(k + 1));

    bss_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .load   (ld),
      .pm_in  (pm_in),
      .pm_out (pm[k]),
      .hit    (hit[k])
    );
  end

  assign found_bit = |(hit & last);

  // ---------------------------------------------------------------------------
  // Beat handling
  // ---------------------------------------------------------------------------
  logic [LIMIT_W:0] tc_inc;
  logic [LIMIT_W:0] pos_full;
  logic             emit;

  assign tc_inc   = {1'b0, tc_r} + 17'd1;
  assign pos_full = tc_inc - (LIMIT_W + 1)'(ml_cur);

  always_comb begin
    done_nxt   = done_r;
    text_nxt   = text_r;
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    tc_nxt     = tc_r;
    ml_nxt     = ml_r;
    emit       = 1'b0;
    status_nxt = status_r;
    pos_nxt    = pos_r;
    row_clear  = 1'b0;
    step       = 1'b0;
    pat_ld     = 1'b0;

    if (acc) begin
      case (op) inside
        OP_START: begin
          done_nxt  = 1'b0;
          text_nxt  = 1'b0;
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          tc_nxt    = '0;
          ml_nxt    = '0;
          row_clear = 1'b1;
          if (tlim_r == '0) begin
            emit       = 1'b1;
            status_nxt = ST_ZERO;
          end else if (tlim_r > LIMIT_W'(MAX_STRING) || plim_r > LIMIT_W'(MAX_STRING)) begin
            emit       = 1'b1;
            status_nxt = ST_TOOLARGE;
          end
        end
        OP_PATTERN: begin
          // Drop pattern bytes while idle, after text began, or when zero
          if (!done_r && !text_r && b != '0) begin
            if (cnt_r < CW'(PATTERN_MAX)) begin
              pat_ld  = 1'b1;
              cnt_nxt = cnt_r + CW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
        OP_TEXT, OP_END: begin
          if (!done_r) begin
            if (!text_r) begin
              text_nxt = 1'b1;
              ml_nxt   = ml_res;
              if (res_empty) begin
                emit       = 1'b1;
                status_nxt = ST_FOUND;
              end else if (plim_r == '0) begin
                emit       = 1'b1;
                status_nxt = ST_ZERO;
              end else if (too_long) begin
                emit       = 1'b1;
                status_nxt = ST_TOOLONG;
              end
            end
            if (!emit) begin
              if (op == OP_END || b == '0) begin
                emit       = 1'b1;
                status_nxt = ST_NOTFOUND;
              end else begin
                step   = 1'b1;
                tc_nxt = tc_inc[LIMIT_W-1:0];
                if (found_bit && tc_inc >= (LIMIT_W + 1)'(ml_cur)) begin
                  emit       = 1'b1;
                  status_nxt = ST_FOUND;
                  pos_nxt    = pos_full[POS_W-1:0];
                end else if (tc_inc >= {1'b0, tlim_r}) begin
                  emit       = 1'b1;
                  status_nxt = ST_NOTFOUND;
                end
              end
            end
          end
        end
      endcase
      if (emit) begin
        done_nxt = 1'b1;
        if (status_nxt != ST_FOUND || !step) begin
          pos_nxt = '0;
        end
      end
    end
  end

  // Load a new result, or drop the old one once taken
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= 1'b1;
      text_r      <= 1'b0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      tc_r        <= '0;
      ml_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      text_r      <= text_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      tc_r        <= tc_nxt;
      ml_r        <= ml_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload holds until the next result
  always_ff @(posedge clk) begin
    if (emit) begin
      status_r <= status_nxt;
      pos_r    <= pos_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {4'd0, pos_r};

`ifndef SYNTH
  // A new result only follows an accepted beat
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(acc))
    else $error("result appeared without an accepted beat");

  // Every emitted result ends the running search
  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> done_r)
    else $error("search still running after a result");

  // The pattern count never runs past the cell row
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(PATTERN_MAX))
    else $error("pattern count beyond the cell row");

  // Only a found result carries a nonzero position
  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != ST_FOUND) |-> (pos_r == '0))
    else $error("nonzero position on a result other than found");
`endif

endmodule

### tb/search_scoreboard_pkg.sv
// Scoreboard for the bounded substring search: result predictor and result check.
`timescale 1ns / 1ps
package search_scoreboard_pkg;
  import bss_pkg::*;

  typedef struct packed {
    status_t            status;
    logic [POS_W-1:0]   position;
  } search_result_t;

  class search_scoreboard;
    logic [LIMIT_W-1:0]        text_limit;
    logic [LIMIT_W-1:0]        pattern_limit;
    bit [BYTE_W-1:0]           pat_store [PATTERN_MAX_DEF];
    bit [PATTERN_MAX_DEF-1:0]  hits;
    int unsigned               pat_count;
    int unsigned               text_count;
    int unsigned               match_len;
    bit                        pat_overflow;
    bit                        idle;
    bit                        in_text;
    search_result_t            expected_q[$];
    int unsigned               live_beats;
    int unsigned               mismatches;

    function new();
      text_limit    = TEXT_LIMIT_RST;
      pattern_limit = PATTERN_LIMIT_RST;
      hits          = '0;
      pat_count     = 0;
      text_count    = 0;
      match_len     = 0;
      pat_overflow  = 1'b0;
      idle          = 1'b1;
      in_text       = 1'b0;
      live_beats    = 0;
      mismatches    = 0;
    endfunction

    function void set_limits(logic [LIMIT_W-1:0] tl, logic [LIMIT_W-1:0] pl);
      text_limit    = tl;
      pattern_limit = pl;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void push_result(status_t st, int unsigned pos);
      search_result_t r;
      r.status   = st;
      r.position = pos[POS_W-1:0];
      expected_q.push_back(r);
      idle = 1'b1;
    endfunction

    // Advance the search state by one accepted input beat.
    function void note_beat(op_t op, logic [BYTE_W-1:0] b);
      if (op == OP_START) begin
        live_beats++;
        idle         = 1'b0;
        in_text      = 1'b0;
        pat_count    = 0;
        pat_overflow = 1'b0;
        text_count   = 0;
        match_len    = 0;
        hits         = '0;
        if (text_limit == 0)
          push_result(ST_ZERO, 0);
        else if (text_limit > MAX_STRING || pattern_limit > MAX_STRING)
          push_result(ST_TOOLARGE, 0);
        return;
      end
      if (idle) return;

      if (op == OP_PATTERN) begin
        if (in_text || b == '0) return;
        live_beats++;
        if (pat_count < PATTERN_MAX_DEF) begin
          pat_store[pat_count] = b;
          pat_count++;
        end else begin
          pat_overflow = 1'b1;
        end
        return;
      end

      live_beats++;
      // first text or end beat settles the length used for the comparison
      if (!in_text) begin
        in_text = 1'b1;
        if (pat_count == 0 && !pat_overflow) begin
          push_result(ST_FOUND, 0);
          return;
        end
        if (pattern_limit == 0) begin
          push_result(ST_ZERO, 0);
          return;
        end
        if (pat_overflow) begin
          if (pattern_limit > PATTERN_MAX_DEF) begin
            push_result(ST_TOOLONG, 0);
            return;
          end
          match_len = pattern_limit;
        end else begin
          match_len = (pat_count < pattern_limit) ? pat_count : pattern_limit;
        end
      end

      if (op == OP_END || b == '0) begin
        push_result(ST_NOTFOUND, 0);
        return;
      end

      text_count++;
      for (int i = int'(match_len) - 1; i >= 1; i--)
        hits[i] = hits[i-1] && (pat_store[i] == b);
      if (match_len >= 1)
        hits[0] = (pat_store[0] == b);

      if (match_len >= 1 && hits[match_len-1] && text_count >= match_len)
        push_result(ST_FOUND, text_count - match_len);
      else if (text_count >= text_limit)
        push_result(ST_NOTFOUND, 0);
    endfunction

    function void record_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] %s", $time, msg);
    endfunction

    // Compare one accepted result beat with the oldest expectation.
    function void check_result(logic [2:0] st, logic [POS_W-1:0] pos);
      search_result_t exp_r;
      if (expected_q.size() == 0) begin
        record_mismatch($sformatf("unexpected result: status %0d position %0d", st, pos));
        return;
      end
      exp_r = expected_q.pop_front();
      if (exp_r.status !== st || exp_r.position !== pos)
        record_mismatch($sformatf(
          "result mismatch: status exp %0d (%s) got %0d, position exp %0d got %0d",
          exp_r.status, exp_r.status.name(), st, exp_r.position, pos));
    endfunction
  endclass

endpackage

### tb/bounded_substring_search_top_tb.sv
// Testbench top for the bounded substring search: stimulus, handshakes and final check.
`timescale 1ns / 1ps
module bounded_substring_search_top_tb;
  import bss_pkg::*;
  import search_scoreboard_pkg::*;

  localparam int unsigned LIVE_BEATS_TARGET = 1000;
  localparam int unsigned QUIET_LIMIT       = 2000;  // idle cycles before giving up
  localparam int unsigned LONG_HOLD         = 300;   // receiver hold-off, in cycles
  localparam int unsigned SETTLE_CYCLES     = 4;     // result lags its beat through the output register

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic [1:0]  in_tuser;   // [1:0] op
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [11:0] position, [15:12] zero
  logic [2:0]  out_tuser;  // [2:0] status
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  search_scoreboard sb = new();

  // Pacing knobs for the sender and receiver processes; quiet_cycles feeds the watchdog
  bit          tx_eager;
  bit          rx_eager;
  bit          hold_req;
  int unsigned quiet_cycles;

  bounded_substring_search_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one beat after a random gap; hold tvalid high afterwards so that
  // back-to-back beats never toggle it within one step.
  task automatic send_beat(op_t op, logic [7:0] b);
    int unsigned gap;
    gap = tx_eager ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_beat(op, b);
  endtask

  // One APB write: setup cycle, then access cycle until pready.
  task automatic apb_write(logic reg_idx, logic [15:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= {16'h0000, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  // Write both limits back to back, then drop the bus.
  task automatic write_limits(logic [15:0] tl, logic [15:0] pl);
    apb_write(REG_TEXT_LIMIT, tl);
    apb_write(REG_PATTERN_LIMIT, pl);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_limits(tl, pl);
  endtask

  // Close any running search, drop tvalid and wait for every result to land.
  task automatic finish_phase();
    send_beat(OP_END, 8'($urandom_range(0, 255)));
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random beats of any kind: mostly ignored, sometimes open a search.
  task automatic send_noise();
    repeat ($urandom_range(1, 4))
      send_beat(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  // One well-formed search over a tiny alphabet so partial matches are common.
  // The pattern is planted in the text about half the time.
  task automatic run_search(int unsigned text_max);
    logic [7:0]  sym [3];
    logic [7:0]  pat [$];
    logic [7:0]  txt [$];
    int unsigned plen;
    int unsigned tlen;
    int unsigned at;
    int unsigned shape;
    int unsigned tail;
    foreach (sym[j]) sym[j] = 8'($urandom_range(1, 255));
    shape = $urandom_range(0, 19);
    if (shape == 0)
      plen = 0;
    else if (shape == 1)
      plen = $urandom_range(60, 70);  // straddle the cell count
    else
      plen = $urandom_range(1, 6);
    repeat (plen) pat.push_back(sym[$urandom_range(0, 2)]);
    tlen = $urandom_range(0, text_max);
    repeat (tlen) txt.push_back(sym[$urandom_range(0, 2)]);
    if (plen > 0 && plen <= tlen && $urandom_range(0, 1) == 1) begin
      at = $urandom_range(0, tlen - plen);
      for (int i = 0; i < plen; i++) txt[at + i] = pat[i];
    end

    send_beat(OP_START, 8'($urandom_range(0, 255)));
    foreach (pat[i]) begin
      if ($urandom_range(0, 11) == 0) send_beat(OP_PATTERN, 8'h00);
      send_beat(OP_PATTERN, pat[i]);
    end
    foreach (txt[i]) begin
      // a late pattern byte must be dropped once text has begun
      if (i > 0 && $urandom_range(0, 23) == 0)
        send_beat(OP_PATTERN, sym[$urandom_range(0, 2)]);
      send_beat(OP_TEXT, txt[i]);
    end
    tail = $urandom_range(0, 9);
    if (tail == 7)
      send_beat(OP_TEXT, 8'h00);
    else if (tail != 8)
      send_beat(OP_END, 8'($urandom_range(0, 255)));
    // tail 8: leave it open, the next start restarts the search
  endtask

  task automatic run_phase(int unsigned tl, int unsigned pl, int unsigned searches,
                           int unsigned text_max);
    write_limits(tl[15:0], pl[15:0]);
    tx_eager = ($urandom_range(0, 3) == 0);
    rx_eager = ($urandom_range(0, 3) == 0);
    repeat (searches) begin
      if ($urandom_range(0, 9) == 0)
        send_noise();
      else
        run_search(text_max);
    end
    finish_phase();
  endtask

  function automatic int unsigned pick_limit(int unsigned short_max);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 65535);
    if (r == 1) return MAX_STRING;
    return $urandom_range(0, short_max);
  endfunction

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= OP_START;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    tx_eager    = 1'b0;
    rx_eager    = 1'b0;
    hold_req    = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats under the reset limits
    // idle block: text and end beats are dropped
    send_beat(OP_TEXT, 8'hFF);
    send_beat(OP_END, 8'h00);
    // empty pattern is found at offset zero
    send_beat(OP_START, 8'h00);
    send_beat(OP_TEXT, 8'h41);
    // zero pattern byte dropped; extreme bytes match at offset one
    send_beat(OP_START, 8'hFF);
    send_beat(OP_PATTERN, 8'h00);
    send_beat(OP_PATTERN, 8'hFF);
    send_beat(OP_PATTERN, 8'h80);
    send_beat(OP_TEXT, 8'h01);
    send_beat(OP_TEXT, 8'hFF);
    send_beat(OP_TEXT, 8'h80);
    // pattern byte after text is dropped; zero text byte ends the text
    send_beat(OP_START, 8'h00);
    send_beat(OP_PATTERN, 8'h7F);
    send_beat(OP_TEXT, 8'h7E);
    send_beat(OP_PATTERN, 8'h7E);
    send_beat(OP_TEXT, 8'h7E);
    send_beat(OP_TEXT, 8'h00);
    // restart mid-search
    send_beat(OP_START, 8'h00);
    send_beat(OP_PATTERN, 8'h11);
    send_beat(OP_START, 8'h00);
    send_beat(OP_PATTERN, 8'h22);
    send_beat(OP_TEXT, 8'h22);
    // end beat with nothing matched
    send_beat(OP_START, 8'h00);
    send_beat(OP_PATTERN, 8'h33);
    send_beat(OP_END, 8'h00);
    // pattern overflows the cell row, trimmed to the limit: found at offset zero
    send_beat(OP_START, 8'h00);
    repeat (PATTERN_MAX_DEF + 2) send_beat(OP_PATTERN, 8'h5A);
    repeat (PATTERN_MAX_DEF) send_beat(OP_TEXT, 8'h5A);
    finish_phase();

    // Limit settings, extremes first
    run_phase(8, 3, 8, 12);           // text limit reached, truncated pattern
    run_phase(0, 64, 3, 6);           // zero text limit
    run_phase(65535, 65535, 3, 6);    // both limits too large
    run_phase(4096, 4097, 3, 6);      // pattern limit just too large
    run_phase(4097, 64, 3, 6);        // text limit just too large
    run_phase(4096, 4096, 3, 80);     // long patterns overflow the cells
    run_phase(100, 0, 5, 10);         // zero pattern limit
    hold_req = 1'b1;                  // stall the receiver while results pile up
    run_phase(1, 1, 10, 4);
    run_phase(4096, 65, 2, 80);       // overflow just past the cell count
    run_phase(200, 64, 2, 100);       // overflow trimmed to the cell count

    // Random settings until enough live beats have gone through
    while (sb.live_beats < LIVE_BEATS_TARGET)
      run_phase(pick_limit(40), pick_limit(70), $urandom_range(4, 8), 30);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver side: random hold-off before each result, one long hold on request
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned gap;
    out_tready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = rx_eager ? 0 : $urandom_range(0, 3);
      if (hold_req) begin
        hold_req = 1'b0;
        gap      = LONG_HOLD;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid === 1'b1 && out_tready));
    end
  end

  // Check every result beat against the predicted stream
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready)
      sb.check_result(out_tuser, out_tdata[POS_W-1:0]);
  end

  // Watchdog: give up after too many cycles without a beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule

### filelist.f
rtl/bss_pkg.sv
rtl/bss_cell.sv
rtl/bounded_substring_search_top.sv
tb/search_scoreboard_pkg.sv
tb/bounded_substring_search_top_tb.sv
